// ----- src/jsu_pkg.sv -----
// jsu_pkg: shared types and constants for the json string unescape unit
// holds beat payload structs, result kinds and error codes
// no dependencies
package jsu_pkg;

    // input beat: one raw byte of the stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in;

    // output beat: one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] error_code;
        logic       last;
    } t_out;

    // every result one input byte produces, up to four
    typedef struct packed {
        logic [2:0]     cnt;
        t_out [3:0]     ent;
    } t_res_set;

    // result kinds
    localparam logic [1:0] K_DATA   = 2'd0;
    localparam logic [1:0] K_CLOSED = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    // error codes
    localparam logic [3:0] E_NONE         = 4'd0;
    localparam logic [3:0] E_NO_QUOTE     = 4'd1;
    localparam logic [3:0] E_UNTERM       = 4'd2;
    localparam logic [3:0] E_UNTERM_ESC   = 4'd3;
    localparam logic [3:0] E_BAD_ESC      = 4'd4;
    localparam logic [3:0] E_BAD_HEX      = 4'd5;
    localparam logic [3:0] E_MISSING_U    = 4'd6;
    localparam logic [3:0] E_BAD_LOW      = 4'd7;
    localparam logic [3:0] E_LONE_LOW     = 4'd8;

    // characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;

    // utf-16 surrogate prefixes (top six bits)
    localparam logic [5:0] SUR_HIGH = 6'b110110;
    localparam logic [5:0] SUR_LOW  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

endpackage

// ----- src/jsu_decode.sv -----
// jsu_decode: escape and surrogate state machine with utf-8 encoder
// produces all results of one input byte combinationally
// depends on jsu_pkg
module jsu_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  jsu_pkg::t_in       i_item,
    output jsu_pkg::t_res_set  o_res
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        M_WAIT = 3'd0,
        M_STR  = 3'd1,
        M_ESC  = 3'd2,
        M_HEX1 = 3'd3,
        M_BSL  = 3'd4,
        M_UCH  = 3'd5,
        M_HEX2 = 3'd6
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_high, n_high;
    logic [15:0] r_low, n_low;

    logic [7:0]  c;
    logic        is_hex;
    logic [3:0]  hv;
    logic [20:0] pair_cp;
    t_res_set    res;

    function automatic t_out mk(input logic [7:0] b, input logic [1:0] k,
                                input logic [3:0] code);
        t_out o;
        o.out_byte   = b;
        o.kind       = k;
        o.error_code = code;
        o.last       = 1'b0;
        return o;
    endfunction

    // code point to one..four utf-8 data results
    function automatic t_res_set utf8(input logic [20:0] cp);
        t_res_set s;
        s = '0;
        if (cp <= 21'h7F) begin
            s.cnt    = 3'd1;
            s.ent[0] = mk(cp[7:0], K_DATA, E_NONE);
        end else if (cp <= 21'h7FF) begin
            s.cnt    = 3'd2;
            s.ent[0] = mk({3'b110, cp[10:6]}, K_DATA, E_NONE);
            s.ent[1] = mk({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else if (cp <= 21'hFFFF) begin
            s.cnt    = 3'd3;
            s.ent[0] = mk({4'b1110, cp[15:12]}, K_DATA, E_NONE);
            s.ent[1] = mk({2'b10, cp[11:6]}, K_DATA, E_NONE);
            s.ent[2] = mk({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else begin
            s.cnt    = 3'd4;
            s.ent[0] = mk({5'b11110, cp[20:18]}, K_DATA, E_NONE);
            s.ent[1] = mk({2'b10, cp[17:12]}, K_DATA, E_NONE);
            s.ent[2] = mk({2'b10, cp[11:6]}, K_DATA, E_NONE);
            s.ent[3] = mk({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
        return s;
    endfunction

    // end of data reads as a zero byte
    assign c = i_item.end_of_data ? 8'h00 : i_item.data_byte;

    // hex digit value, either case
    always_comb begin
        is_hex = 1'b1;
        hv     = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hv = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hv = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            is_hex = 1'b0;
        end
    end

    // supplementary code point from the stored high unit and the low unit being completed
    assign pair_cp = {1'b0, r_high[9:0], r_low[5:0], hv} + SUPP_BASE;

    // next state and results
    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_high = r_high;
        n_low  = r_low;
        res    = '0;
        unique case (r_mode)
            M_STR: begin
                if (c == 8'h00) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_UNTERM);
                end else if (c == CH_QUOTE) begin
                    n_mode = M_WAIT;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_CLOSED, E_NONE);
                end else if (c == CH_BSL) begin
                    n_mode = M_ESC;
                end else begin
                    res.cnt = 3'd1; res.ent[0] = mk(c, K_DATA, E_NONE);
                end
            end
            M_ESC: begin
                n_mode  = M_STR;
                res.cnt = 3'd1;
                if (c == 8'h00) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.ent[0] = mk(8'h00, K_ERROR, E_UNTERM_ESC);
                end else if (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH) begin
                    res.ent[0] = mk(c, K_DATA, E_NONE);
                end else if (c == CH_N) begin
                    res.ent[0] = mk(8'h0A, K_DATA, E_NONE);
                end else if (c == CH_T) begin
                    res.ent[0] = mk(8'h09, K_DATA, E_NONE);
                end else if (c == CH_R) begin
                    res.ent[0] = mk(8'h0D, K_DATA, E_NONE);
                end else if (c == CH_B) begin
                    res.ent[0] = mk(8'h08, K_DATA, E_NONE);
                end else if (c == CH_F) begin
                    res.ent[0] = mk(8'h0C, K_DATA, E_NONE);
                end else if (c == CH_U) begin
                    n_mode = M_HEX1; n_hex = 2'd0; n_high = 16'h0000;
                    res.cnt = 3'd0;
                end else begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.ent[0] = mk(8'h00, K_ERROR, E_BAD_ESC);
                end
            end
            M_HEX1: begin
                if (!is_hex) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_BAD_HEX);
                end else begin
                    n_high = {r_high[11:0], hv};
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex = 2'd0;
                        if (n_high[15:10] == SUR_HIGH) begin
                            n_mode = M_BSL;
                        end else if (n_high[15:10] == SUR_LOW) begin
                            n_mode = M_WAIT;
                            res.cnt = 3'd1;
                            res.ent[0] = mk(8'h00, K_ERROR, E_LONE_LOW);
                        end else begin
                            n_mode = M_STR;
                            res = utf8({5'b00000, n_high});
                        end
                    end
                end
            end
            M_BSL: begin
                if (c != CH_BSL) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_MISSING_U);
                end else begin
                    n_mode = M_UCH;
                end
            end
            M_UCH: begin
                if (c != CH_U) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_MISSING_U);
                end else begin
                    n_mode = M_HEX2; n_hex = 2'd0; n_low = 16'h0000;
                end
            end
            M_HEX2: begin
                if (!is_hex) begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_BAD_HEX);
                end else begin
                    n_low = {r_low[11:0], hv};
                    if (r_hex != 2'd3) begin
                        n_hex = r_hex + 2'd1;
                    end else begin
                        n_hex = 2'd0;
                        if (n_low[15:10] != SUR_LOW) begin
                            n_mode = M_WAIT;
                            res.cnt = 3'd1;
                            res.ent[0] = mk(8'h00, K_ERROR, E_BAD_LOW);
                        end else begin
                            n_mode = M_STR;
                            res = utf8(pair_cp);
                        end
                    end
                end
            end
            default: begin
                // waiting for the opening quote
                if (c == CH_QUOTE) begin
                    n_mode = M_STR; n_hex = 2'd0;
                end else begin
                    n_mode = M_WAIT; n_hex = 2'd0;
                    res.cnt = 3'd1; res.ent[0] = mk(8'h00, K_ERROR, E_NO_QUOTE);
                end
            end
        endcase
    end

    // mark the final result of this byte
    always_comb begin
        o_res = res;
        for (int k = 0; k < 4; k++) begin
            o_res.ent[k].last = ((3'(k) + 3'd1) == res.cnt);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_WAIT;
            r_hex  <= 2'd0;
            r_high <= 16'h0000;
            r_low  <= 16'h0000;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

// ----- src/jsu_out_buf.sv -----
// jsu_out_buf: result register holding up to four results of one byte
// shifts them out one beat per cycle on the output channel while the output is ready
// depends on jsu_pkg
module jsu_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  jsu_pkg::t_res_set  i_res,
    output logic               o_load_ok,
    output logic               o_valid,
    input  logic               i_ready,
    output jsu_pkg::t_out      o_data
);
    import jsu_pkg::*;

    t_out [3:0] r_ent;
    logic [2:0] r_cnt;
    logic       take;

    assign o_valid   = (r_cnt != 3'd0);
    assign o_data    = r_ent[0];
    assign take      = o_valid && i_ready;
    // free now, or its final beat leaves this cycle
    assign o_load_ok = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_ready);

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res.ent;
        end else if (take) begin
            for (int k = 0; k < 3; k++) begin
                r_ent[k] <= r_ent[k + 1];
            end
        end
    end

    // pending beat count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

endmodule

// ----- src/json_string_unescape_utf8_unit.sv -----
// json_string_unescape_utf8_unit: top level of the json string decoder
// input register, decode state machine and output result register
// depends on jsu_pkg, jsu_decode, jsu_out_buf
//
// Takes a JSON string literal one byte per beat and returns its decoded
// UTF-8 bytes, a closed marker at the closing quote, or one coded error
// (after which it waits for a new opening quote). Each byte passes an
// input register and is decoded combinationally into the result register.
// A byte yielding zero or one result lets the next byte in while the
// output is ready; a byte completing a \u escape yields one to four
// UTF-8 bytes and holds the input while the result register shifts them
// out one per cycle when the output is ready. The last flag marks the
// final result of each byte; bytes yielding no result produce no beat.
module json_string_unescape_utf8_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jsu_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output jsu_pkg::t_out  o_out_data
);
    import jsu_pkg::*;

    t_in       r_in;
    logic      r_in_vld;
    logic      load_ok;
    logic      fire;
    t_res_set  res;

    assign fire       = r_in_vld && load_ok;
    assign o_in_ready = !r_in_vld || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // decode
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (res)
    );

    // result register
    jsu_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_res     (res),
        .o_load_ok (load_ok),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for json_string_unescape_utf8_unit
// clocked driver and monitor around the unit, with an in-bench decoder model that predicts results
// depends on jsu_pkg and json_string_unescape_utf8_unit
`timescale 1ns / 100ps

module tb;
    import jsu_pkg::*;

    // decoder modes of the in-bench model
    typedef enum logic [2:0] {
        ST_WAIT, ST_STR, ST_ESC, ST_HEX1, ST_BSL, ST_UCH, ST_HEX2
    } t_mode;

    // one pending input beat; drain holds it back until all results are in
    typedef struct {
        t_in beat;
        bit  drain;
    } t_item;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_X  = 8'h78;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] ESC_CH [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_N,
                                          CH_T, CH_R, CH_B, CH_F};
    localparam int RAND_ITEMS = 250;

    logic  i_clk = 1'b1;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_out  o_out_data;

    json_string_unescape_utf8_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_item       byte_q[$];
    t_out        utf8_q[$];
    t_out        step_res[4];
    int          step_n;
    t_mode       mode_m = ST_WAIT;
    logic [1:0]  hex_n = '0;
    logic [15:0] hi_unit = '0;
    logic [15:0] lo_unit = '0;

    bit          in_fire, out_fire, rx_block, pend_drain;
    int unsigned n_items, n_in, n_out, n_sent, n_err;
    int          tx_gap, rx_wait;

    // ---------------- decoder model ----------------

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd16;
        if (c >= CH_0 && c <= CH_9) d = c - CH_0;
        else if (c >= CH_LA && c <= CH_LF) d = c - CH_LA + 8'd10;
        else if (c >= CH_UA && c <= CH_UF) d = c - CH_UA + 8'd10;
        return d[4:0];
    endfunction

    task automatic emit(input logic [7:0] b, input logic [1:0] k, input logic [3:0] code);
        t_out r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = code;
        r.last       = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endtask

    task automatic fail_with(input logic [3:0] code);
        mode_m = ST_WAIT;
        hex_n  = '0;
        emit(8'h00, K_ERROR, code);
    endtask

    task automatic put_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit(cp[7:0], K_DATA, E_NONE);
        end else if (cp <= 21'h7FF) begin
            emit({3'b110, cp[10:6]}, K_DATA, E_NONE);
            emit({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else if (cp <= 21'hFFFF) begin
            emit({4'b1110, cp[15:12]}, K_DATA, E_NONE);
            emit({2'b10, cp[11:6]}, K_DATA, E_NONE);
            emit({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else begin
            emit({5'b11110, cp[20:18]}, K_DATA, E_NONE);
            emit({2'b10, cp[17:12]}, K_DATA, E_NONE);
            emit({2'b10, cp[11:6]}, K_DATA, E_NONE);
            emit({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
    endtask

    // advance the model by one accepted beat and queue what it yields
    task automatic decode_beat(input t_in bt);
        logic [7:0] c;
        logic [4:0] h;
        t_out       r;
        c = bt.end_of_data ? 8'h00 : bt.data_byte;
        step_n = 0;
        case (mode_m)
            ST_STR: begin
                if (c == 8'h00) fail_with(E_UNTERM);
                else if (c == CH_QUOTE) begin
                    mode_m = ST_WAIT;
                    emit(8'h00, K_CLOSED, E_NONE);
                end else if (c == CH_BSL) mode_m = ST_ESC;
                else emit(c, K_DATA, E_NONE);
            end
            ST_ESC: begin
                if (c == 8'h00) begin
                    fail_with(E_UNTERM_ESC);
                end else begin
                    mode_m = ST_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: emit(c, K_DATA, E_NONE);
                        CH_N: emit(BYTE_LF, K_DATA, E_NONE);
                        CH_T: emit(BYTE_TAB, K_DATA, E_NONE);
                        CH_R: emit(BYTE_CR, K_DATA, E_NONE);
                        CH_B: emit(BYTE_BS, K_DATA, E_NONE);
                        CH_F: emit(BYTE_FF, K_DATA, E_NONE);
                        CH_U: begin
                            mode_m  = ST_HEX1;
                            hex_n   = '0;
                            hi_unit = '0;
                        end
                        default: fail_with(E_BAD_ESC);
                    endcase
                end
            end
            ST_HEX1: begin
                h = hex_value(c);
                if (h[4]) begin
                    fail_with(E_BAD_HEX);
                end else begin
                    hi_unit = {hi_unit[11:0], h[3:0]};
                    if (hex_n != 2'd3) begin
                        hex_n++;
                    end else begin
                        hex_n = '0;
                        if (hi_unit[15:10] == SUR_HIGH) mode_m = ST_BSL;
                        else if (hi_unit[15:10] == SUR_LOW) fail_with(E_LONE_LOW);
                        else begin
                            mode_m = ST_STR;
                            put_utf8({5'd0, hi_unit});
                        end
                    end
                end
            end
            ST_BSL: begin
                if (c != CH_BSL) fail_with(E_MISSING_U);
                else mode_m = ST_UCH;
            end
            ST_UCH: begin
                if (c != CH_U) begin
                    fail_with(E_MISSING_U);
                end else begin
                    mode_m  = ST_HEX2;
                    hex_n   = '0;
                    lo_unit = '0;
                end
            end
            ST_HEX2: begin
                h = hex_value(c);
                if (h[4]) begin
                    fail_with(E_BAD_HEX);
                end else begin
                    lo_unit = {lo_unit[11:0], h[3:0]};
                    if (hex_n != 2'd3) begin
                        hex_n++;
                    end else begin
                        hex_n = '0;
                        if (lo_unit[15:10] != SUR_LOW) fail_with(E_BAD_LOW);
                        else begin
                            mode_m = ST_STR;
                            put_utf8(SUPP_BASE + {1'b0, hi_unit[9:0], lo_unit[9:0]});
                        end
                    end
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    mode_m = ST_STR;
                    hex_n  = '0;
                end else fail_with(E_NO_QUOTE);
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            utf8_q.insert(utf8_q.size(), r);
        end
    endtask

    // ---------------- checking ----------------

    task automatic note_mismatch(input string msg);
        n_err++;
        if (n_err <= 10) $display("%s", msg);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (utf8_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result: byte %h kind %0d code %0d last %b",
                got.out_byte, got.kind, got.error_code, got.last));
        end else begin
            want = utf8_q.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.error_code !== want.error_code || got.last !== want.last)
                note_mismatch($sformatf(
                    "mismatch at result %0d: got byte %h kind %0d code %0d last %b, %s",
                    n_out, got.out_byte, got.kind, got.error_code, got.last,
                    $sformatf("want byte %h kind %0d code %0d last %b",
                        want.out_byte, want.kind, want.error_code, want.last)));
        end
    endtask

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (in_fire) begin
            decode_beat(i_in_data);
            n_in++;
        end
        if (out_fire) begin
            check_result(o_out_data);
            n_out++;
        end
    end

    // ---------------- driving ----------------

    // sender: one beat per item, random gap after each, no gaps in calm stretches or while the receiver is blocked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (tx_gap != 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_q.size() != 0 && !(byte_q[0].drain && utf8_q.size() != 0)) begin
                i_in_data  <= byte_q[0].beat;
                i_in_valid <= 1'b1;
                tx_gap = (rx_block || (n_sent % 64) < 12) ? 0 : $urandom_range(0, 8);
                void'(byte_q.pop_front());
                n_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall before each result, none in calm stretches
    always @(negedge i_clk) begin
        if (out_fire) rx_wait = ((n_out % 64) < 12) ? 0 : $urandom_range(0, 8);
        if (!i_rst_n || rx_block) begin
            i_out_ready <= 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // long receiver hold-off while the sender keeps offering beats
    initial begin
        wait (n_in >= 80);
        @(posedge i_clk);
        rx_block = 1'b1;
        repeat (100) @(posedge i_clk);
        rx_block = 1'b0;
    end

    // ---------------- stimulus ----------------

    task automatic put(input logic [7:0] c, input logic eod = 1'b0);
        t_item it;
        it.beat.data_byte   = c;
        it.beat.end_of_data = eod;
        it.drain            = pend_drain;
        pend_drain = 1'b0;
        byte_q.insert(byte_q.size(), it);
        n_items++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_0 + nib;
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + nib - 8'd10;
    endfunction

    task automatic put_hex4(input logic [15:0] v);
        put(hex_char(v[15:12]));
        put(hex_char(v[11:8]));
        put(hex_char(v[7:4]));
        put(hex_char(v[3:0]));
    endtask

    task automatic put_uesc(input logic [15:0] v);
        put(CH_BSL);
        put(CH_U);
        put_hex4(v);
    endtask

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [4:0] h;
        c = 8'($urandom_range(0, 255));
        h = hex_value(c);
        while (!h[4]) begin
            c = 8'($urandom_range(0, 255));
            h = hex_value(c);
        end
        return c;
    endfunction

    function automatic bit is_escape(input logic [7:0] c);
        foreach (ESC_CH[i]) if (c == ESC_CH[i]) return 1'b1;
        return c == CH_U;
    endfunction

    // terminating byte: zero, or end of data over a random byte
    task automatic put_end();
        if ($urandom_range(0, 1)) put(8'h00);
        else put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_element();
        logic [7:0]  c;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                c = 8'($urandom_range(1, 255));
                while (c == CH_QUOTE || c == CH_BSL) c = 8'($urandom_range(1, 255));
                put(c);
            end
            4, 5: begin
                put(CH_BSL);
                put(ESC_CH[$urandom_range(0, 7)]);
            end
            6, 7, 8: begin
                case ($urandom_range(0, 2))
                    0: v = 16'($urandom_range(0, 16'h7F));
                    1: v = 16'($urandom_range(16'h80, 16'h7FF));
                    default: v = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                if (v[15:11] == 5'b11011) v = v ^ 16'h2000;
                put_uesc(v);
            end
            default: begin
                put_uesc(16'(16'hD800 | $urandom_range(0, 16'h3FF)));
                put_uesc(16'(16'hDC00 | $urandom_range(0, 16'h3FF)));
            end
        endcase
    endtask

    task automatic put_good_string();
        put(CH_QUOTE);
        repeat ($urandom_range(0, 6)) put_element();
        put(CH_QUOTE);
    endtask

    // every broken sequence ends in an error (noise bytes give one each), leaving the unit waiting for a quote
    task automatic put_broken();
        logic [7:0] c;
        case ($urandom_range(0, 8))
            0: repeat ($urandom_range(1, 3)) begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE) c = 8'($urandom_range(0, 255));
                put(c, $urandom_range(0, 3) == 0);
            end
            1: begin
                put(CH_QUOTE);
                repeat ($urandom_range(0, 3)) put_element();
                put_end();
            end
            2: begin
                put(CH_QUOTE);
                if ($urandom_range(0, 1)) put_element();
                put(CH_BSL);
                c = 8'($urandom_range(1, 255));
                while (is_escape(c)) c = 8'($urandom_range(1, 255));
                put(c);
            end
            3: begin
                put(CH_QUOTE);
                put(CH_BSL);
                put_end();
            end
            4: begin
                put(CH_QUOTE);
                put(CH_BSL);
                put(CH_U);
                repeat ($urandom_range(0, 3)) put(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 3) == 0) put(8'($urandom_range(0, 255)), 1'b1);
                else put(rand_non_hex());
            end
            5: begin
                put(CH_QUOTE);
                put_uesc(16'(16'hD800 | $urandom_range(0, 16'h3FF)));
                if ($urandom_range(0, 1)) put(CH_BSL);
                c = 8'($urandom_range(0, 255));
                while (c == CH_BSL || c == CH_U) c = 8'($urandom_range(0, 255));
                put(c, $urandom_range(0, 2) == 0);
            end
            6: begin
                put(CH_QUOTE);
                put_uesc(16'(16'hD800 | $urandom_range(0, 16'h3FF)));
                put_uesc(16'((16'hDC00 | $urandom_range(0, 16'h3FF)) ^
                             (16'h0400 << $urandom_range(0, 5))));
            end
            7: begin
                put(CH_QUOTE);
                put_uesc(16'(16'hDC00 | $urandom_range(0, 16'h3FF)));
            end
            default: begin
                put(CH_QUOTE);
                put_uesc(16'(16'hD800 | $urandom_range(0, 16'h3FF)));
                put(CH_BSL);
                put(CH_U);
                repeat ($urandom_range(0, 3)) put(hex_char(4'($urandom_range(0, 15))));
                put(rand_non_hex());
            end
        endcase
    endtask

    // main sequence
    initial begin
        int unsigned directed_n;
        bit          mid_pause;

        // directed: junk before the quote, extremes, escapes, surrogate pair, end in hex
        put(CH_X);
        put(8'hFF, 1'b1);
        put(8'h00);
        put(CH_QUOTE);
        put(8'hFF);
        put(8'h01);
        put(CH_BSL);
        put(CH_N);
        put_uesc(16'h0000);
        put_uesc(16'hDBFF);
        put_uesc(16'hDFFF);
        put(CH_QUOTE);
        put(CH_QUOTE);
        put(CH_BSL);
        put(CH_U);
        put(hex_char(4'hA));
        put(8'h00, 1'b1);
        directed_n = n_items;

        // random: mostly well-formed strings, the rest broken sequences and noise
        pend_drain = 1'b1;
        mid_pause  = 1'b0;
        while (n_items < directed_n + RAND_ITEMS) begin
            if (!mid_pause && n_items > directed_n + RAND_ITEMS / 2) begin
                pend_drain = 1'b1;
                mid_pause  = 1'b1;
            end
            if ($urandom_range(0, 99) < 78) put_good_string();
            else put_broken();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_in == n_items && utf8_q.size() == 0);
        repeat (16) @(posedge i_clk);
        if (n_err == 0 && utf8_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #500000;
        $display("status: fail");
        $finish;
    end

endmodule
